[hdl/pli_pkg.sv]
`timescale 1ns / 1ps
package pli_pkg;

   localparam int MAX_DIMS   = 4;
   localparam int MAX_EXTENT = 64;
   localparam int NDIM       = 4;

   localparam int IDX_W  = 26;
   localparam int CRD_W  = 6;
   localparam int EXT_W  = 7;
   localparam int DIM_W  = 3;
   localparam int CMD_W  = 3;
   localparam int DIR_W  = 2;
   localparam int CIN_W  = 16;
   localparam int ABS_W  = 17;
   localparam int REC_W  = 32;
   localparam int STR_W  = 19;
   localparam int VOL_W  = 25;
   localparam int DVOL_W = 27;
   localparam int CSR_IW = 3;

   localparam logic [CMD_W-1:0] CMD_C2S  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_S2C  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SFWD = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SBWD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LFWD = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LBWD = 3'd5;

   localparam logic [CSR_IW-1:0] REG_DIMS  = 3'd0;
   localparam logic [CSR_IW-1:0] REG_EXT_0 = 3'd1;
   localparam logic [CSR_IW-1:0] REG_EXT_1 = 3'd2;
   localparam logic [CSR_IW-1:0] REG_EXT_2 = 3'd3;
   localparam logic [CSR_IW-1:0] REG_EXT_3 = 3'd4;

   typedef struct packed {
      logic                          busy;
      logic [DIM_W-1:0]              dims;
      logic [NDIM-1:0][EXT_W-1:0]    ext;
      logic [NDIM-1:0][REC_W-1:0]    rec;
      logic [REC_W-1:0]              rec_dims;
      logic [NDIM-1:0][STR_W-1:0]    stride;
      logic [VOL_W-1:0]              vol;
      logic [DVOL_W-1:0]             dvol;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]              cmd;
      logic [IDX_W-1:0]              idx;
      logic [DIR_W-1:0]              dir;
      logic [NDIM-1:0]               neg;
      logic [NDIM-1:0][ABS_W-1:0]    mag;
      logic [1:0]                    lmu;
      logic [NDIM-1:0][EXT_W-1:0]    rem;
   } side_type;

   typedef struct packed {
      logic [CMD_W-1:0]              cmd;
      logic [1:0]                    lmu;
      logic                          fault;
      logic [NDIM-1:0][CRD_W-1:0]    oc;
   } tail_type;

endpackage

[hdl/pli_divstep.sv]
`timescale 1ns / 1ps
module pli_divstep (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pli_pkg::IDX_W-1:0]   x,
   input  logic [pli_pkg::EXT_W-1:0]   e,
   input  logic [pli_pkg::REC_W-1:0]   m,
   output logic [pli_pkg::IDX_W-1:0]   q,
   output logic [pli_pkg::EXT_W-1:0]   r
);
   import pli_pkg::*;

   // quotient estimate by reciprocal, then one correction step
   logic [IDX_W+REC_W-1:0] prod;
   logic [IDX_W-1:0]       q1_ff, q1_in, x1_ff;
   logic [IDX_W+EXT_W-1:0] t;
   logic [EXT_W:0]         d;
   logic [IDX_W-1:0]       q_ff, q_in;
   logic [EXT_W-1:0]       r_ff, r_in;

   assign prod  = {{REC_W{1'b0}}, x} * {{IDX_W{1'b0}}, m};
   assign q1_in = prod[IDX_W+REC_W-1:REC_W];

   always_comb begin
      t = {{EXT_W{1'b0}}, q1_ff} * {{IDX_W{1'b0}}, e};
      d = x1_ff[EXT_W:0] - t[EXT_W:0];
      if (d >= {1'b0, e}) begin
         q_in = q1_ff + 1'b1;
         r_in = EXT_W'(d - {1'b0, e});
      end else begin
         q_in = q1_ff;
         r_in = d[EXT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff <= q1_in;
         x1_ff <= x;
         q_ff  <= q_in;
         r_ff  <= r_in;
      end
   end

   assign q = q_ff;
   assign r = r_ff;
endmodule

[hdl/pli_cfg.sv]
`timescale 1ns / 1ps
module pli_cfg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [pli_pkg::CSR_IW-1:0]   csr_index,
   input  logic [pli_pkg::EXT_W-1:0]    csr_data,
   output pli_pkg::cfg_type             cfg
);
   import pli_pkg::*;

   localparam logic [2:0] SETTLE = 3'd7;

   logic [DIM_W-1:0]           num_dims_ff;
   logic [NDIM-1:0][EXT_W-1:0] ext_ff;
   logic [2:0]                 cnt_ff, cnt_in;

   logic [NDIM-1:0][EXT_W-1:0] eff_ff, eff_in;
   logic [DIM_W-1:0]           dims_ff, dims_in;
   logic [NDIM-1:0][REC_W-1:0] rec_ff;
   logic [REC_W-1:0]           recd_ff;
   logic [NDIM-1:0][STR_W-1:0] str_ff, str_in;
   logic [VOL_W-1:0]           vol_ff, vol_in;
   logic [DVOL_W-1:0]          dvol_ff, dvol_in;
   logic [1:0]                 top_k;

   logic [REC_W-1:0] rec_lut [0:MAX_EXTENT];

   assign rec_lut[0] = '1;
   for (genvar g = 1; g <= MAX_EXTENT; g++) begin : g_rec
      localparam logic [REC_W-1:0] RV = 32'hFFFF_FFFF / g;
      assign rec_lut[g] = RV;
   end

   always_comb begin
      for (int k = 0; k < NDIM; k++) begin
         if (ext_ff[k] == '0)
            eff_in[k] = EXT_W'(1);
         else if (ext_ff[k] > EXT_W'(MAX_EXTENT))
            eff_in[k] = EXT_W'(MAX_EXTENT);
         else
            eff_in[k] = ext_ff[k];
      end
      if (num_dims_ff == '0)
         dims_in = DIM_W'(1);
      else if (num_dims_ff > DIM_W'(MAX_DIMS))
         dims_in = DIM_W'(MAX_DIMS);
      else
         dims_in = num_dims_ff;
      str_in[0] = STR_W'(1);
      for (int k = 1; k < NDIM; k++)
         str_in[k] = STR_W'(str_ff[k-1] * {{(STR_W-EXT_W){1'b0}}, eff_ff[k-1]});
      top_k  = 2'(dims_ff - 1'b1);
      vol_in = VOL_W'({{(VOL_W-STR_W){1'b0}}, str_ff[top_k]}
                      * {{(VOL_W-EXT_W){1'b0}}, eff_ff[top_k]});
      dvol_in = DVOL_W'({{(DVOL_W-VOL_W){1'b0}}, vol_ff}
                        * {{(DVOL_W-DIM_W){1'b0}}, dims_ff});
      cnt_in = csr_valid ? SETTLE : ((cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= DIM_W'(4);
         for (int k = 0; k < NDIM; k++) ext_ff[k] <= EXT_W'(8);
         cnt_ff <= SETTLE;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_valid) begin
            case (csr_index)
               REG_DIMS:  num_dims_ff <= csr_data[DIM_W-1:0];
               REG_EXT_0: ext_ff[0] <= csr_data;
               REG_EXT_1: ext_ff[1] <= csr_data;
               REG_EXT_2: ext_ff[2] <= csr_data;
               REG_EXT_3: ext_ff[3] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      eff_ff  <= eff_in;
      dims_ff <= dims_in;
      for (int k = 0; k < NDIM; k++) rec_ff[k] <= rec_lut[eff_in[k]];
      recd_ff <= rec_lut[{{(EXT_W-DIM_W){1'b0}}, dims_in}];
      str_ff  <= str_in;
      vol_ff  <= vol_in;
      dvol_ff <= dvol_in;
   end

   always_comb begin
      cfg.busy     = (cnt_ff != '0);
      cfg.dims     = dims_ff;
      cfg.ext      = eff_ff;
      cfg.rec      = rec_ff;
      cfg.rec_dims = recd_ff;
      cfg.stride   = str_ff;
      cfg.vol      = vol_ff;
      cfg.dvol     = dvol_ff;
   end
endmodule

[hdl/periodic_lattice_index_unit.sv]
`timescale 1ns / 1ps
// Periodic lattice address unit. One item is taken every cycle while req_stall is
// low; a stall on the result side holds the whole pipeline.
// The pipeline is an input stage, a divide by the dimension count, four
// reciprocal divide steps (two stages each, one per dimension) that split the
// index or wrap the coordinates, then coordinate update, stride multiply, sum,
// link rebuild and the output register. After reset and after each register
// write, req_stall stays high while strides, volume and reciprocals are
// recomputed.
module periodic_lattice_index_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pli_pkg::CMD_W-1:0]     req_command,
   input  logic [pli_pkg::IDX_W-1:0]     req_in_index,
   input  logic [pli_pkg::DIR_W-1:0]     req_direction,
   input  logic signed [pli_pkg::CIN_W-1:0] req_coord_0,
   input  logic signed [pli_pkg::CIN_W-1:0] req_coord_1,
   input  logic signed [pli_pkg::CIN_W-1:0] req_coord_2,
   input  logic signed [pli_pkg::CIN_W-1:0] req_coord_3,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pli_pkg::IDX_W-1:0]     rsp_out_index,
   output logic [pli_pkg::CRD_W-1:0]     rsp_site_coord_0,
   output logic [pli_pkg::CRD_W-1:0]     rsp_site_coord_1,
   output logic [pli_pkg::CRD_W-1:0]     rsp_site_coord_2,
   output logic [pli_pkg::CRD_W-1:0]     rsp_site_coord_3,
   output logic                          rsp_fault,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pli_pkg::CSR_IW-1:0]    csr_index,
   input  logic [pli_pkg::EXT_W-1:0]     csr_data
);
   import pli_pkg::*;

   localparam int NS = 11;

   cfg_type cfg;
   logic    adv;

   logic [NS-1:0]  vld_ff, vld_in;
   side_type       side_ff [NS];
   side_type       side_in [NS];
   logic [CIN_W-1:0] cin [NDIM];

   logic [IDX_W-1:0] dq_d;
   logic [EXT_W-1:0] dr_d;
   logic [IDX_W-1:0] dq [NDIM];
   logic [EXT_W-1:0] dr [NDIM];
   logic [IDX_W-1:0] dx [NDIM];

   logic [3:0]                 vt_ff, vt_in;
   tail_type                   t11_ff, t11_in, t12_ff, t13_ff, t14_ff;
   logic [NDIM-1:0][EXT_W-1:0] c_ff, c_in;
   logic [NDIM-1:0][IDX_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]           site_ff, site_in, site14_ff;
   logic [DVOL_W-1:0]          lprod_ff, lprod_in;

   logic                       ovld_ff;
   logic [IDX_W-1:0]           oidx_ff, oidx_in;
   logic [NDIM-1:0][CRD_W-1:0] oc_ff, oc_in;
   logic                       ofault_ff, ofault_in;

   pli_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;
   assign adv       = !ovld_ff || !rsp_stall;
   assign req_stall = !adv || cfg.busy;

   assign cin[0] = req_coord_0;
   assign cin[1] = req_coord_1;
   assign cin[2] = req_coord_2;
   assign cin[3] = req_coord_3;

   function automatic logic is_link(input logic [CMD_W-1:0] c);
      return (c == CMD_LFWD) || (c == CMD_LBWD);
   endfunction

   pli_divstep u_div_d (
      .clock (clock), .en (adv), .x (side_ff[0].idx),
      .e     ({{(EXT_W-DIM_W){1'b0}}, cfg.dims}), .m (cfg.rec_dims),
      .q     (dq_d), .r (dr_d)
   );

   for (genvar k = 0; k < NDIM; k++) begin : g_div
      if (k == 0) begin : g_first
         assign dx[k] = (side_ff[2].cmd == CMD_C2S)
                      ? {{(IDX_W-ABS_W){1'b0}}, side_ff[2].mag[0]}
                      : (is_link(side_ff[2].cmd) ? dq_d : side_ff[2].idx);
      end else begin : g_next
         assign dx[k] = (side_ff[2+2*k].cmd == CMD_C2S)
                      ? {{(IDX_W-ABS_W){1'b0}}, side_ff[2+2*k].mag[k]}
                      : dq[k-1];
      end
      pli_divstep u_div (
         .clock (clock), .en (adv), .x (dx[k]), .e (cfg.ext[k]),
         .m     (cfg.rec[k]), .q (dq[k]), .r (dr[k])
      );
   end

   always_comb begin
      vld_in[0]      = req_valid && !cfg.busy;
      side_in[0]     = side_ff[0];
      side_in[0].cmd = req_command;
      side_in[0].idx = req_in_index;
      side_in[0].dir = req_direction;
      side_in[0].lmu = '0;
      side_in[0].rem = '0;
      for (int k = 0; k < NDIM; k++) begin
         side_in[0].neg[k] = cin[k][CIN_W-1];
         side_in[0].mag[k] = cin[k][CIN_W-1]
                           ? ABS_W'(ABS_W'(0) - {1'b1, cin[k]})
                           : {1'b0, cin[k]};
      end
      for (int i = 1; i < NS; i++) begin
         vld_in[i]  = vld_ff[i-1];
         side_in[i] = side_ff[i-1];
      end
      side_in[3].lmu = dr_d[1:0];
      for (int k = 0; k < NDIM-1; k++)
         side_in[5+2*k].rem[k] = dr[k];
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv)
         for (int i = 0; i < NS; i++) side_ff[i] <= side_in[i];
   end

   // coordinate update and range checks
   always_comb begin
      logic [EXT_W-1:0] e, r, v;
      logic [CMD_W-1:0] cmd;
      logic             link;
      side_type         s;
      s    = side_ff[NS-1];
      cmd  = s.cmd;
      link = is_link(cmd);
      t11_in.cmd = cmd;
      t11_in.lmu = s.lmu;
      t11_in.fault = (cmd > CMD_LBWD)
         || ((cmd == CMD_S2C || cmd == CMD_SFWD || cmd == CMD_SBWD)
             && ({{(DVOL_W-IDX_W){1'b0}}, s.idx} >= {{(DVOL_W-VOL_W){1'b0}}, cfg.vol}))
         || (link && ({{(DVOL_W-IDX_W){1'b0}}, s.idx} >= cfg.dvol))
         || ((cmd >= CMD_SFWD) && ({1'b0, s.dir} >= cfg.dims));
      for (int k = 0; k < NDIM; k++) begin
         e = cfg.ext[k];
         r = (k == NDIM-1) ? dr[NDIM-1] : s.rem[k];
         v = r;
         if (cmd == CMD_C2S) begin
            if (s.neg[k] && r != '0) v = e - r;
         end else if (s.dir == 2'(k)) begin
            if (cmd == CMD_SFWD || cmd == CMD_LFWD)
               v = (r + 1'b1 == e) ? '0 : r + 1'b1;
            else
               v = (r == '0) ? e - 1'b1 : r - 1'b1;
         end
         if (DIM_W'(k) >= cfg.dims) v = '0;
         c_in[k]      = v;
         t11_in.oc[k] = (cmd == CMD_S2C && !t11_in.fault) ? r[CRD_W-1:0] : '0;
      end
   end

   always_comb begin
      site_in  = '0;
      for (int k = 0; k < NDIM; k++) begin
         prod_in[k] = IDX_W'({{(IDX_W-EXT_W){1'b0}}, c_ff[k]}
                             * {{(IDX_W-STR_W){1'b0}}, cfg.stride[k]});
         site_in    = site_in + prod_ff[k];
      end
      lprod_in = DVOL_W'({{(DVOL_W-IDX_W){1'b0}}, site_ff}
                         * {{(DVOL_W-DIM_W){1'b0}}, cfg.dims});
      if (t14_ff.fault || t14_ff.cmd == CMD_S2C)
         oidx_in = '0;
      else if (is_link(t14_ff.cmd))
         oidx_in = IDX_W'(lprod_ff + {{(DVOL_W-2){1'b0}}, t14_ff.lmu});
      else
         oidx_in = site14_ff;
      oc_in     = t14_ff.oc;
      ofault_in = t14_ff.fault;
      vt_in     = {vt_ff[2:0], vld_ff[NS-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff   <= '0;
         ovld_ff <= 1'b0;
      end else if (adv) begin
         vt_ff   <= vt_in;
         ovld_ff <= vt_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t11_ff    <= t11_in;
         c_ff      <= c_in;
         t12_ff    <= t11_ff;
         prod_ff   <= prod_in;
         t13_ff    <= t12_ff;
         site_ff   <= site_in;
         t14_ff    <= t13_ff;
         site14_ff <= site_ff;
         lprod_ff  <= lprod_in;
         oidx_ff   <= oidx_in;
         oc_ff     <= oc_in;
         ofault_ff <= ofault_in;
      end
   end

   assign rsp_valid        = ovld_ff;
   assign rsp_out_index    = oidx_ff;
   assign rsp_site_coord_0 = oc_ff[0];
   assign rsp_site_coord_1 = oc_ff[1];
   assign rsp_site_coord_2 = oc_ff[2];
   assign rsp_site_coord_3 = oc_ff[3];
   assign rsp_fault        = ofault_ff;

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_out_index == '0 && oc_ff == '0)
      else $error("fault result carries data");

   a_coord_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_index != '0 |-> oc_ff == '0)
      else $error("coordinates with an index result");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      cfg.busy |-> req_stall)
      else $error("item taken while config settles");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff) && $stable(vt_ff))
      else $error("pipeline moved during stall");
endmodule

[test/periodic_lattice_index_unit_tb.sv]
`timescale 1ns / 1ps
module periodic_lattice_index_unit_tb;
   import pli_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic [CRD_W-1:0] crd [4];
      logic             fault;
   } lattice_rsp_type;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [DIR_W-1:0] dir;
      logic [CIN_W-1:0] c [4];
      bit               has_exp;
      logic [IDX_W-1:0] exp_idx;
      logic             exp_fault;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic [IDX_W-1:0] req_in_index = '0;
   logic [DIR_W-1:0] req_direction = '0;
   logic signed [CIN_W-1:0] req_coord_0 = '0, req_coord_1 = '0;
   logic signed [CIN_W-1:0] req_coord_2 = '0, req_coord_3 = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [IDX_W-1:0] rsp_out_index;
   logic [CRD_W-1:0] rsp_site_coord_0, rsp_site_coord_1;
   logic [CRD_W-1:0] rsp_site_coord_2, rsp_site_coord_3;
   logic rsp_fault;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [EXT_W-1:0] csr_data = '0;

   periodic_lattice_index_unit u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow registers
   logic [DIM_W-1:0] dims_reg;
   logic [EXT_W-1:0] ext_reg [4];

   lattice_rsp_type expected_q [$];
   int errors = 0;
   bit calm = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint eff_dims();
      longint d = dims_reg;
      if (d < 1) d = 1;
      if (d > MAX_DIMS) d = MAX_DIMS;
      return d;
   endfunction

   function automatic longint eff_ext(int k);
      longint e = ext_reg[k];
      if (e < 1) e = 1;
      if (e > MAX_EXTENT) e = MAX_EXTENT;
      return e;
   endfunction

   function automatic longint step_site(longint site, int mu, bit fwd);
      longint stride = 1, e, x, nx;
      for (int k = 0; k < mu; k++) stride *= eff_ext(k);
      e = eff_ext(mu);
      x = (site / stride) % e;
      if (fwd) nx = (x + 1 == e) ? 0 : x + 1;
      else nx = (x == 0) ? e - 1 : x - 1;
      return site - x * stride + nx * stride;
   endfunction

   function automatic lattice_rsp_type lattice_address(input logic [CMD_W-1:0] cmd,
         input logic [IDX_W-1:0] idx_in, input logic [DIR_W-1:0] dir,
         input logic [CIN_W-1:0] c [4]);
      lattice_rsp_type r;
      longint dims = eff_dims(), vol = 1, res = 0, idx = idx_in, stride = 1;
      longint e, v, site;
      bit f = 0;
      for (int k = 0; k < 4; k++) r.crd[k] = '0;
      for (int k = 0; k < dims; k++) vol *= eff_ext(k);
      case (cmd)
         CMD_C2S: begin
            for (int k = 0; k < dims; k++) begin
               e = eff_ext(k);
               v = longint'($signed(c[k])) % e;
               if (v < 0) v += e;
               res += v * stride;
               stride *= e;
            end
         end
         CMD_S2C: begin
            if (idx >= vol) f = 1;
            else for (int k = 0; k < dims; k++) begin
               r.crd[k] = idx % eff_ext(k);
               idx /= eff_ext(k);
            end
         end
         CMD_SFWD, CMD_SBWD: begin
            if (idx >= vol || dir >= dims) f = 1;
            else res = step_site(idx, dir, cmd == CMD_SFWD);
         end
         CMD_LFWD, CMD_LBWD: begin
            if (idx >= dims * vol || dir >= dims) f = 1;
            else begin
               site = step_site(idx / dims, dir, cmd == CMD_LFWD);
               res = idx % dims + dims * site;
            end
         end
         default: f = 1;
      endcase
      if (f) begin
         res = 0;
         for (int k = 0; k < 4; k++) r.crd[k] = '0;
      end
      r.idx = res[IDX_W-1:0];
      r.fault = f;
      return r;
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
         input logic [DIR_W-1:0] dir, input logic [CIN_W-1:0] c [4]);
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_in_index <= idx;
      req_direction <= dir;
      req_coord_0 <= c[0];
      req_coord_1 <= c[1];
      req_coord_2 <= c[2];
      req_coord_3 <= c[3];
      expected_q.push_back(lattice_address(cmd, idx, dir, c));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] ix, input logic [EXT_W-1:0] val);
      csr_valid <= 1;
      csr_index <= ix;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (ix)
         REG_DIMS: dims_reg = val[DIM_W-1:0];
         REG_EXT_0: ext_reg[0] = val;
         REG_EXT_1: ext_reg[1] = val;
         REG_EXT_2: ext_reg[2] = val;
         REG_EXT_3: ext_reg[3] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= !calm && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      lattice_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report("unexpected item", rsp_out_index, 0);
         end else begin
            w = expected_q.pop_front();
            if (rsp_out_index !== w.idx) report("out_index", rsp_out_index, w.idx);
            if (rsp_site_coord_0 !== w.crd[0]) report("coord0", rsp_site_coord_0, w.crd[0]);
            if (rsp_site_coord_1 !== w.crd[1]) report("coord1", rsp_site_coord_1, w.crd[1]);
            if (rsp_site_coord_2 !== w.crd[2]) report("coord2", rsp_site_coord_2, w.crd[2]);
            if (rsp_site_coord_3 !== w.crd[3]) report("coord3", rsp_site_coord_3, w.crd[3]);
            if (rsp_fault !== w.fault) report("fault", rsp_fault, w.fault);
         end
      end
   end

   // directed rows at reset config: 4 dims, extent 8, volume 4096
   dir_row_type dir_rows [$];

   function automatic dir_row_type mk(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
         logic [DIR_W-1:0] dir, logic [CIN_W-1:0] c0, logic [CIN_W-1:0] c1,
         logic [CIN_W-1:0] c2, logic [CIN_W-1:0] c3, bit he,
         logic [IDX_W-1:0] ei, logic ef);
      dir_row_type r;
      r.cmd = cmd; r.idx = idx; r.dir = dir;
      r.c[0] = c0; r.c[1] = c1; r.c[2] = c2; r.c[3] = c3;
      r.has_exp = he; r.exp_idx = ei; r.exp_fault = ef;
      return r;
   endfunction

   task automatic random_phase(int n);
      logic [CIN_W-1:0] c [4];
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      longint vol = 1;
      for (int k = 0; k < eff_dims(); k++) vol *= eff_ext(k);
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 4; k++)
            c[k] = ($urandom_range(3) == 0) ? CIN_W'($urandom) :
                   CIN_W'($urandom_range(200) - 100);
         cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(7, 6))
                                         : CMD_W'($urandom_range(5));
         case ($urandom_range(9))
            0: idx = IDX_W'($urandom);
            1: idx = IDX_W'(vol * eff_dims() - 1 + $urandom_range(1));
            2: idx = IDX_W'(vol - 1 + $urandom_range(1));
            default: idx = IDX_W'($urandom % ((cmd >= CMD_LFWD) ? vol * eff_dims() : vol));
         endcase
         send_item(cmd, idx, DIR_W'($urandom), c);
      end
   endtask

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [CIN_W-1:0] c [4];
      lattice_rsp_type got;
      dims_reg = 4;
      for (int k = 0; k < 4; k++) ext_reg[k] = 8;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir_rows.push_back(mk(CMD_C2S, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      dir_rows.push_back(mk(CMD_C2S, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            1, 4095, 0));
      dir_rows.push_back(mk(CMD_C2S, 0, 0, 16'h7fff, 16'h8000, 16'h0009, 16'hfff7,
                            1, 7 + 64 + 7 * 512, 0));
      dir_rows.push_back(mk(CMD_S2C, 4095, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_S2C, 4096, 0, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(CMD_S2C, 26'h3ffffff, 0, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(CMD_SFWD, 7, 0, 0, 0, 0, 0, 1, 0, 0));
      dir_rows.push_back(mk(CMD_SBWD, 0, 0, 0, 0, 0, 0, 1, 7, 0));
      dir_rows.push_back(mk(CMD_SFWD, 4095, 3, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_SBWD, 100, 2, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_SFWD, 4096, 1, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(CMD_LFWD, 16383, 3, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_LBWD, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(CMD_LFWD, 16384, 0, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(CMD_LBWD, 26'h3ffffff, 0, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      dir_rows.push_back(mk(3'd7, 5, 1, 0, 0, 0, 0, 1, 0, 1));
      foreach (dir_rows[i]) begin
         c = dir_rows[i].c;
         if (dir_rows[i].has_exp) begin
            got = lattice_address(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].dir, c);
            if (got.idx !== dir_rows[i].exp_idx || got.fault !== dir_rows[i].exp_fault)
               report("directed row", i, dir_rows[i].exp_idx);
         end
         send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].dir, c);
      end
      drain();

      // dims 2, small extents; direction past dims faults
      write_reg(REG_DIMS, 2);
      write_reg(REG_EXT_0, 3);
      write_reg(REG_EXT_1, 5);
      random_phase(150);
      drain();
      // out-of-range register values, clamped
      write_reg(REG_DIMS, 0);
      write_reg(REG_EXT_0, 127);
      random_phase(100);
      drain();
      write_reg(REG_DIMS, 7);
      write_reg(REG_EXT_0, 64);
      write_reg(REG_EXT_1, 64);
      write_reg(REG_EXT_2, 64);
      write_reg(REG_EXT_3, 64);
      calm = 1;
      random_phase(150);
      calm = 0;
      random_phase(150);
      drain();
      write_reg(REG_DIMS, 3);
      write_reg(REG_EXT_0, 1);
      write_reg(REG_EXT_1, 0);
      write_reg(REG_EXT_2, 7'h55);
      write_reg(REG_EXT_3, 2);
      random_phase(150);
      drain();
      write_reg(REG_DIMS, 4);
      write_reg(REG_EXT_0, 5);
      write_reg(REG_EXT_1, 2);
      write_reg(REG_EXT_2, 42);
      write_reg(REG_EXT_3, 3);
      random_phase(230);
      drain();

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

[periodic_lattice_index_unit.f]
hdl/pli_pkg.sv
hdl/pli_divstep.sv
hdl/pli_cfg.sv
hdl/periodic_lattice_index_unit.sv
test/periodic_lattice_index_unit_tb.sv
